[rtl/array_doubly_linked_list_assert.svh]
// Assertion macros for the linked list block.
// Define ASSERT_OFF to compile the checks out.
`ifndef ARRAY_DOUBLY_LINKED_LIST_ASSERT_SVH
`define ARRAY_DOUBLY_LINKED_LIST_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition a implies condition c in the same cycle.
`define ADLL_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Condition a implies condition c in the next cycle.
`define ADLL_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`else

`define ADLL_ASSERT_SAME(label, clk, rst, a, c)
`define ADLL_ASSERT_NEXT(label, clk, rst, a, c)

`endif

`endif

[rtl/adll_pkg.sv]
package adll_pkg;

  // Command codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  // Input beat
  typedef struct packed {
    logic               command;
    logic signed [31:0] key_value;
    logic [4:0]         slot_index;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [4:0] slot;
    logic [1:0] status;
    logic [4:0] head_after;
  } res_t;

endpackage

[rtl/adll_ram.sv]
module adll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/array_doubly_linked_list.sv]
// Doubly linked list of keys kept in slot memories, with a free list.
// Slots are numbered 1..SLOTS; slot number 0 means none.
// Input: a request beat (command, key_value, slot_index) is taken at a
// rising edge with start high and busy low. Add puts the key in the slot at
// the head of the free list and links it in at the list head; remove unlinks
// slot_index and pushes it onto the free list.
// Output: every request gives one result beat (slot, status, head_after),
// shown for one cycle with done high. The receiver cannot stall; results
// are never held back.
// Sequence from the accepting edge: requests rejected on decode (list full,
// slot 0, out of range or never allocated) set done at that edge; all others
// read the link memories and enter ST_READ. A remove of a slot that is
// currently free and an add into an empty list finish from ST_READ; an add
// into a non-empty list and a good remove go on through ST_WR2. The writes
// fall in ST_READ and ST_WR2, as each memory has one write port. busy is
// low in the cycle done is high, so a new request may be accepted then.
// Reset: the list is empty and all slots are free in ascending order. Slots
// never allocated are tracked by a fill counter, so no clearing pass runs
// and the block accepts a request in the first cycle after reset.
module array_doubly_linked_list
  import adll_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output res_t result
);

`include "array_doubly_linked_list_assert.svh"

  localparam int IW = $clog2(SLOTS + 1);
  localparam int FW = $clog2(SLOTS + 2);
  localparam int CW = ((FW > 5) ? FW : 5) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WR2  = 2'd2;

  logic [1:0]         state;
  logic               op_cmd;
  logic signed [31:0] op_key;
  logic [IW-1:0]      op_idx;
  logic [IW-1:0]      old_head;
  logic [IW-1:0]      lk_prev;
  logic [IW-1:0]      lk_next;
  logic [IW-1:0]      list_head;
  logic [IW-1:0]      free_head;
  logic [FW-1:0]      fresh;
  logic [4:0]         res_slot;
  logic [1:0]         res_status;
  logic [4:0]         res_head;

  logic [31:0] key_mem [SLOTS + 1];

  // Memory ports
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] nx_rdata;
  logic [IW:0]   pw_rdata;
  logic          nx_we;
  logic [IW-1:0] nx_waddr;
  logic [IW-1:0] nx_wdata;
  logic          pw_we;
  logic [IW-1:0] pw_waddr;
  logic [IW:0]   pw_wdata;

  // Decoded request checks
  logic [CW-1:0] idx_wide;
  logic          idx_ok;
  logic          req_go;
  logic [IW-1:0] free_after;

  function automatic logic [4:0] to_slot5(input logic [IW-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return w[4:0];
  endfunction

  assign busy   = (state != ST_IDLE);
  assign result = '{slot: res_slot, status: res_status, head_after: res_head};

  assign idx_wide = CW'(request.slot_index);
  assign idx_ok   = (idx_wide != '0) && (idx_wide <= CW'(SLOTS)) && (idx_wide < CW'(fresh));
  assign req_go   = (request.command == CMD_ADD) ? (free_head != '0) : idx_ok;

  // Next free head: slots past the fill counter still chain in order
  always_comb begin
    if (FW'(op_idx) == fresh) begin
      free_after = (op_idx == IW'(SLOTS)) ? '0 : op_idx + IW'(1);
    end else begin
      free_after = nx_rdata;
    end
  end

  // Read and write port selection
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = free_head;
    nx_we    = 1'b0;
    nx_waddr = op_idx;
    nx_wdata = list_head;
    pw_we    = 1'b0;
    pw_waddr = op_idx;
    pw_wdata = '0;
    unique case (state)
      ST_IDLE: begin
        rd_en   = start && req_go;
        rd_addr = (request.command == CMD_ADD) ? free_head : IW'(request.slot_index);
      end
      ST_READ: begin
        if (op_cmd == CMD_ADD) begin
          nx_we    = 1'b1;
          nx_wdata = list_head;
          pw_we    = 1'b1;
          pw_wdata = '0;
          pw_wdata[IW] = 1'b1;
        end else if (pw_rdata[IW]) begin
          nx_we    = 1'b1;
          nx_wdata = free_head;
          pw_we    = 1'b1;
          pw_wdata = '0;
        end
      end
      ST_WR2: begin
        if (op_cmd == CMD_ADD) begin
          pw_we    = 1'b1;
          pw_waddr = old_head;
          pw_wdata = {1'b1, op_idx};
        end else begin
          nx_we    = (lk_prev != '0);
          nx_waddr = lk_prev;
          nx_wdata = lk_next;
          pw_we    = (lk_next != '0);
          pw_waddr = lk_next;
          pw_wdata = {1'b1, lk_prev};
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  adll_ram #(.WIDTH(IW), .DEPTH(SLOTS + 1)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (nx_rdata)
  );

  // Word holds the in-use flag over the prev link
  adll_ram #(.WIDTH(IW + 1), .DEPTH(SLOTS + 1)) u_prev_ram (
    .clk   (clk),
    .we    (pw_we),
    .waddr (pw_waddr),
    .wdata (pw_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (pw_rdata)
  );

  // Key store, written on add
  always_ff @(posedge clk) begin
    if (state == ST_READ && op_cmd == CMD_ADD) begin
      key_mem[op_idx] <= op_key;
    end
  end

  // Sequencer and list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      list_head <= '0;
      free_head <= IW'(1);
      fresh     <= FW'(1);
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            op_cmd <= request.command;
            op_key <= request.key_value;
            op_idx <= (request.command == CMD_ADD) ? free_head : IW'(request.slot_index);
            if (req_go) begin
              state <= ST_READ;
              done  <= 1'b0;
            end else begin
              done       <= 1'b1;
              res_slot   <= '0;
              res_status <= (request.command == CMD_ADD) ? STAT_FULL : STAT_INVALID;
              res_head   <= to_slot5(list_head);
            end
          end else begin
            done <= 1'b0;
          end
        end
        ST_READ: begin
          if (op_cmd == CMD_ADD) begin
            free_head <= free_after;
            if (FW'(op_idx) == fresh) begin
              fresh <= fresh + FW'(1);
            end
            old_head   <= list_head;
            list_head  <= op_idx;
            res_slot   <= to_slot5(op_idx);
            res_status <= STAT_OK;
            res_head   <= to_slot5(op_idx);
            if (list_head != '0) begin
              state <= ST_WR2;
              done  <= 1'b0;
            end else begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end
          end else if (!pw_rdata[IW]) begin
            state      <= ST_IDLE;
            done       <= 1'b1;
            res_slot   <= '0;
            res_status <= STAT_INVALID;
            res_head   <= to_slot5(list_head);
          end else begin
            lk_prev    <= pw_rdata[IW-1:0];
            lk_next    <= nx_rdata;
            free_head  <= op_idx;
            res_slot   <= to_slot5(op_idx);
            res_status <= STAT_OK;
            if (pw_rdata[IW-1:0] == '0) begin
              list_head <= nx_rdata;
              res_head  <= to_slot5(nx_rdata);
            end else begin
              res_head  <= to_slot5(list_head);
            end
            state <= ST_WR2;
            done  <= 1'b0;
          end
        end
        ST_WR2: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // Checks
  `ADLL_ASSERT_SAME(a_done_idle, clk, rst, done, state == ST_IDLE)
  `ADLL_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, done || busy)
  `ADLL_ASSERT_SAME(a_fresh_free, clk, rst, CW'(fresh) <= CW'(SLOTS), free_head != '0)

endmodule
